// File: rtl/core/rua_pkg.sv
`default_nettype none
package rua_pkg;

    localparam int COORD_W = 8;
    localparam int AREA_W  = 15;
    localparam int MAP_W   = 64;
    localparam int CNT_W   = 7;

    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [AREA_W-1:0]  t_area;
    typedef logic [MAP_W-1:0]   t_map_word;
    typedef logic [CNT_W-1:0]   t_cnt;

endpackage
`default_nettype wire

// File: rtl/core/rua_if.sv
`default_nettype none
interface rua_in_if
    import rua_pkg::*;
    ();
    logic   valid;
    logic   ready;
    logic   start_new_set;
    t_coord x_low;
    t_coord y_low;
    t_coord x_high;
    t_coord y_high;

    modport source (output valid, start_new_set, x_low, y_low, x_high, y_high, input ready);
    modport sink   (input valid, start_new_set, x_low, y_low, x_high, y_high, output ready);
endinterface

interface rua_out_if
    import rua_pkg::*;
    ();
    logic  valid;
    logic  ready;
    t_area union_area;

    modport source (output valid, union_area, input ready);
    modport sink   (input valid, union_area, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rua_ram.sv
`default_nettype none
module rua_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/rectangle_union_area_unit.sv
`default_nettype none
// Running union area of axis-aligned rectangles on a GRID_SIZE by GRID_SIZE cell grid, kept
// as a bitmap of 64-bit words in one RAM. Each word covers cells [x_low, x_high) by
// [y_low, y_high), clipped to the grid, and returns one word with the area so far. After
// reset, and before any word whose start_new_set flag is set, a clearing sweep writes every
// map word, one per cycle, (GRID_SIZE*GRID_SIZE+63)/64 words (256 at the default size);
// no word is taken during it. A rectangle is worked through each map word touched in each
// covered row in turn, since the map RAM does one read-modify-write per cycle. An empty or
// inverted rectangle returns the area unchanged without touching the map. The area
// saturates at 32767. A finished result waits in an output register while the next word is
// already taken.
module rectangle_union_area_unit
    import rua_pkg::*;
#(
    parameter int GRID_SIZE = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rua_in_if.sink     i_in,
    rua_out_if.source  o_out
);

    localparam int WORDS = (GRID_SIZE * GRID_SIZE + MAP_W - 1) / MAP_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = AW + 6;
    localparam int CLIP  = (GRID_SIZE > 255) ? 255 : GRID_SIZE;

    localparam logic [CW-1:0] ROW_STEP  = CW'(GRID_SIZE);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam t_coord        CLIP_MAX  = COORD_W'(CLIP);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_ROW,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state        r_state;
    logic          r_pend;
    logic [AW-1:0] r_clr;
    t_coord        r_xl, r_yl, r_xh, r_yh;
    t_coord        r_rows;
    logic [CW-1:0] r_base, r_p, r_e;
    logic          r_b_valid;
    logic [AW-1:0] r_b_addr;
    t_map_word     r_b_mask;
    logic          r_w_valid;
    logic [AW-1:0] r_w_addr;
    t_map_word     r_w_data;
    logic          r_c_valid;
    t_cnt          r_c_cnt;
    t_area         r_area;
    logic          r_ov;
    t_area         r_out_area;

    logic [AW-1:0] cur_word;
    logic          seg_last;
    logic [5:0]    seg_hi;
    t_map_word     seg_mask;
    t_map_word     rdata, old_word, new_bits, wdata;
    logic          we;
    logic [AW-1:0] waddr;
    t_cnt          new_cnt;
    logic [AREA_W:0] area_sum;
    t_area         n_area;
    logic [CW-1:0] n_base;
    logic          accept, out_free, out_load;

    function automatic t_coord clip(input t_coord v);
        return (v > CLIP_MAX) ? CLIP_MAX : v;
    endfunction

    always_comb begin
        cur_word = r_p[CW-1:6];
        seg_last = (r_e[CW-1:6] == cur_word);
        seg_hi   = seg_last ? r_e[5:0] : 6'd63;
        seg_mask = ({MAP_W{1'b1}} << r_p[5:0]) & ({MAP_W{1'b1}} >> (6'd63 - seg_hi));
        n_base   = r_base + ROW_STEP;
    end

    always_comb begin
        old_word = (r_w_valid && (r_w_addr == r_b_addr)) ? r_w_data : rdata;
        new_bits = r_b_mask & ~old_word;
        new_cnt  = CNT_W'($countones(new_bits));
        we       = (r_state == S_CLEAR) || r_b_valid;
        waddr    = (r_state == S_CLEAR) ? r_clr : r_b_addr;
        wdata    = (r_state == S_CLEAR) ? '0 : (old_word | r_b_mask);
        area_sum = {1'b0, r_area} + (AREA_W + 1)'(r_c_cnt);
        n_area   = (area_sum > {1'b0, AREA_MAX}) ? AREA_MAX : area_sum[AREA_W-1:0];
    end

    rua_ram #(
        .WIDTH (MAP_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (cur_word),
        .o_rdata (rdata)
    );

    assign accept           = i_in.valid && i_in.ready;
    assign out_free         = !r_ov || o_out.ready;
    assign out_load         = (r_state == S_DRAIN) && !r_b_valid && !r_c_valid && out_free;
    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ov;
    assign o_out.union_area = r_out_area;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pend    <= 1'b0;
            r_clr     <= '0;
            r_b_valid <= 1'b0;
            r_w_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_area    <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_w_valid <= r_b_valid;
            r_w_addr  <= r_b_addr;
            r_w_data  <= wdata;
            r_c_valid <= r_b_valid;
            r_c_cnt   <= new_cnt;
            r_b_valid <= (r_state == S_RUN);
            if (r_c_valid) begin
                r_area <= n_area;
            end
            r_ov <= out_load || (r_ov && !o_out.ready);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == LAST_WORD) begin
                        r_pend  <= 1'b0;
                        r_state <= r_pend ? S_SETUP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_xl <= clip(i_in.x_low);
                        r_yl <= clip(i_in.y_low);
                        r_xh <= clip(i_in.x_high);
                        r_yh <= clip(i_in.y_high);
                        if (i_in.start_new_set) begin
                            r_area  <= '0;
                            r_clr   <= '0;
                            r_pend  <= 1'b1;
                            r_state <= S_CLEAR;
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    if ((r_xl < r_xh) && (r_yl < r_yh)) begin
                        r_base  <= CW'(32'(r_xl) * GRID_SIZE);
                        r_rows  <= r_xh - r_xl;
                        r_state <= S_ROW;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_ROW: begin
                    r_p     <= r_base + CW'(r_yl);
                    r_e     <= r_base + CW'(r_yh) - CW'(1);
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_b_addr  <= cur_word;
                    r_b_mask  <= seg_mask;
                    if (!seg_last) begin
                        r_p <= {cur_word + AW'(1), 6'd0};
                    end else if (r_rows > COORD_W'(1)) begin
                        r_rows <= r_rows - COORD_W'(1);
                        r_base <= n_base;
                        r_p    <= n_base + CW'(r_yl);
                        r_e    <= n_base + CW'(r_yh) - CW'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (out_load) begin
                        r_out_area <= r_area;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_pipe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("map update pending outside a rectangle");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_b_valid && !r_c_valid))
        else $error("map update overlaps the clearing sweep");

    a_mask_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (seg_mask != '0))
        else $error("empty segment mask issued");

    a_area_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |=> (r_area >= $past(r_area)))
        else $error("union area decreased within a set");
`endif

endmodule
`default_nettype wire
